// ===== src/wpse_pkg.sv =====
// Shared types and constants for the WAV PCM16 stream extractor.
`timescale 1ns / 1ps

package wpse_pkg;

  // Parser phases of the front end.
  typedef enum logic [2:0] {
    PH_RIFF   = 3'd0,
    PH_ID     = 3'd1,
    PH_SIZE   = 3'd2,
    PH_SKIP   = 3'd3,
    PH_DSIZE  = 3'd4,
    PH_SAMPLE = 3'd5
  } phase_e;

  // Result status codes, carried on the output tuser.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_DATA = 2'd1,
    ST_PARTIAL = 2'd2
  } status_e;

  localparam int unsigned  SampleW   = 17;
  localparam logic [5:0]   ChanOffset = 6'd22;
  localparam logic [5:0]   RiffLen    = 6'd11;
  localparam logic [5:0]   OffsetSat  = 6'd35;
  localparam logic [31:0]  DataId     = 32'h6461_7461;
  localparam logic [7:0]   StereoCnt  = 8'd2;

  // One classified byte handed from the parser to the sample assembler.
  typedef struct packed {
    logic [7:0] data;    // file byte
    logic       last;    // final byte of the file
    logic       sample;  // byte belongs to the sample data
    logic       stereo;  // channel count in force is two
  } wpse_tok_t;

endpackage

// ===== src/wpse_fifo.sv =====
// Small token queue between the chunk parser and the sample assembler.
`timescale 1ns / 1ps

module wpse_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  wpse_pkg::wpse_tok_t tok_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output wpse_pkg::wpse_tok_t tok_o
);
  import wpse_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  wpse_tok_t        mem_q [Depth];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [AW:0]      cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(Depth));
  assign valid_o = (cnt_q != '0);
  assign tok_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= tok_i;
    end
  end

endmodule

// ===== src/wpse_front.sv =====
// Chunk parser: walks the RIFF header and chunks and classifies each byte.
`timescale 1ns / 1ps

module wpse_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  output logic                push_o,
  output wpse_pkg::wpse_tok_t tok_o
);
  import wpse_pkg::*;

  phase_e      phase_q, phase_d;
  logic [5:0]  off_q, off_d;
  logic [1:0]  idx_q, idx_d;
  logic [31:0] id_q, id_d;
  logic [31:0] size_q, size_d;
  logic [31:0] skip_q, skip_d;
  logic [7:0]  chan_q, chan_d;
  logic [31:0] id_next, size_next, skip_next;

  assign id_next   = {id_q[23:0], byte_i};
  assign size_next = size_q | ({24'd0, byte_i} << {idx_q, 3'b000});
  assign skip_next = skip_q - 32'd1;

  always_comb begin
    phase_d = phase_q;
    off_d   = (off_q < OffsetSat) ? off_q + 6'd1 : off_q;
    idx_d   = idx_q;
    id_d    = id_q;
    size_d  = size_q;
    skip_d  = skip_q;
    chan_d  = (off_q == ChanOffset) ? byte_i : chan_q;

    case (phase_q)
      PH_ID: begin
        id_d = id_next;
        if (idx_q == 2'd3) begin
          idx_d   = '0;
          size_d  = '0;
          phase_d = (id_next == DataId) ? PH_DSIZE : PH_SIZE;
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end
      PH_SIZE: begin
        size_d = size_next;
        if (idx_q == 2'd3) begin
          idx_d   = '0;
          skip_d  = size_next;
          id_d    = '0;
          phase_d = (size_next == '0) ? PH_ID : PH_SKIP;
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end
      PH_SKIP: begin
        skip_d = skip_next;
        if (skip_next == '0) begin
          phase_d = PH_ID;
        end
      end
      PH_DSIZE: begin
        if (idx_q == 2'd3) begin
          idx_d   = '0;
          phase_d = PH_SAMPLE;
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end
      PH_SAMPLE: begin
        phase_d = PH_SAMPLE;
      end
      default: begin
        // RIFF header skip; any unused code behaves the same way.
        if (off_q >= RiffLen) begin
          phase_d = PH_ID;
          idx_d   = '0;
          id_d    = '0;
        end
      end
    endcase

    // The final byte returns the parser to its reset state.
    if (last_i) begin
      phase_d = PH_RIFF;
      off_d   = '0;
      idx_d   = '0;
      id_d    = '0;
      size_d  = '0;
      skip_d  = '0;
      chan_d  = '0;
    end
  end

  // Only sample bytes and the final byte matter downstream.
  assign push_o       = fire_i && ((phase_q == PH_SAMPLE) || last_i);
  assign tok_o.data   = byte_i;
  assign tok_o.last   = last_i;
  assign tok_o.sample = (phase_q == PH_SAMPLE);
  assign tok_o.stereo = (((off_q == ChanOffset) ? byte_i : chan_q) == StereoCnt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_RIFF;
      off_q   <= '0;
      idx_q   <= '0;
      id_q    <= '0;
      size_q  <= '0;
      skip_q  <= '0;
      chan_q  <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      off_q   <= off_d;
      idx_q   <= idx_d;
      id_q    <= id_d;
      size_q  <= size_d;
      skip_q  <= skip_d;
      chan_q  <= chan_d;
    end
  end

endmodule

// ===== src/wpse_back.sv =====
// Sample assembler: builds frames from sample bytes and drives the result register.
`timescale 1ns / 1ps

module wpse_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  wpse_pkg::wpse_tok_t      tok_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [16:0]       out_sample_o,
  output wpse_pkg::status_e        out_status_o,
  output logic                     out_last_o
);
  import wpse_pkg::*;

  logic [1:0]          fp_q, fp_d;
  logic [7:0]          low_q, low_d;
  logic [15:0]         left_q, left_d;
  logic                ov_q;
  logic signed [16:0]  val_q, val_d;
  status_e             st_q, st_d;
  logic                last_q;
  logic                emit, res;
  logic [15:0]         word;

  assign word  = {tok_i.data, low_q};
  assign pop_o = valid_i && (!ov_q || out_ready_i);

  always_comb begin
    fp_d   = fp_q;
    low_d  = low_q;
    left_d = left_q;
    emit   = 1'b0;
    val_d  = '0;
    if (tok_i.sample) begin
      if (!fp_q[0]) begin
        low_d = tok_i.data;
        fp_d  = fp_q + 2'd1;
      end else if (fp_q == 2'd1) begin
        left_d = word;
        if (tok_i.stereo) begin
          fp_d = 2'd2;
        end else begin
          emit  = 1'b1;
          val_d = {word, 1'b0};
          fp_d  = '0;
        end
      end else begin
        emit  = 1'b1;
        val_d = 17'($signed(left_q)) + 17'($signed(word));
        fp_d  = '0;
      end
    end
    if (tok_i.last) begin
      fp_d = '0;
    end

    res  = emit || tok_i.last;
    st_d = ST_OK;
    if (tok_i.last && !emit) begin
      val_d = '0;
      st_d  = tok_i.sample ? ST_PARTIAL : ST_NO_DATA;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fp_q <= '0;
      ov_q <= 1'b0;
    end else begin
      if (pop_o) begin
        fp_q <= fp_d;
        ov_q <= res;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      low_q  <= low_d;
      left_q <= left_d;
      if (res) begin
        val_q  <= val_d;
        st_q   <= st_d;
        last_q <= tok_i.last;
      end
    end
  end

  assign out_valid_o  = ov_q;
  assign out_sample_o = val_q;
  assign out_status_o = st_q;
  assign out_last_o   = last_q;

endmodule

// ===== src/wav_pcm16_stream_extractor.sv =====
// Top level of the WAV PCM16 stream extractor: parser, token queue and assembler.
`timescale 1ns / 1ps

// The block takes a WAV file one byte per transfer on the slave stream, with
// tlast on the final byte of the file, and gives one mixed sample per audio
// frame on the master stream. It takes one byte every clock cycle while the
// queue has room: the chunk parser decides the role of each byte in the cycle
// it arrives, the sample assembler takes one byte per pop, and so the rate is
// set only by the output side taking its transfers. Each result carries a
// 17-bit signed value in units of 1/32768 (left plus right for two channels,
// twice the sample otherwise) and a status on tuser: sample valid, end of file
// before any sample data, or end of file with a partial frame dropped. The
// result caused by the final byte has tlast set, and after it the block is
// back in its reset state, ready for the next file. The channel count is
// taken from byte offset 22 of the file, whatever that byte happens to be.
// An accepted byte is registered in the token queue and then in the result
// register before its result is given on the master stream.

module wav_pcm16_stream_extractor #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] file_byte
  input  logic        s_axis_tlast_i,   // end_of_file
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [16:0] mixed_sample, [23:17] zero
  output logic [1:0]  m_axis_tuser_o,   // [1:0] status
  output logic        m_axis_tlast_o    // is_last
);
  import wpse_pkg::*;

  logic               in_fire;
  logic               push, full, fifo_valid, pop;
  wpse_tok_t          tok_in, tok_out;
  logic signed [16:0] sample;
  status_e            status;

  // Input is taken whenever the queue has room; the queue decouples the
  // parser from stalls on the output stream.
  assign s_axis_tready_o = !full;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  wpse_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (in_fire),
    .byte_i (s_axis_tdata_i),
    .last_i (s_axis_tlast_i),
    .push_o (push),
    .tok_o  (tok_in)
  );

  wpse_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .tok_i   (tok_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .tok_o   (tok_out)
  );

  wpse_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (fifo_valid),
    .tok_i        (tok_out),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_sample_o (sample),
    .out_status_o (status),
    .out_last_o   (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {7'd0, sample};
  assign m_axis_tuser_o = status;

  // An error status always comes with a zero sample.
  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o != ST_OK)) |-> (m_axis_tdata_o == '0))
    else $error("error status with nonzero sample");

  // Error statuses are only given for the final byte of a file.
  a_err_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o != ST_OK)) |-> m_axis_tlast_o)
    else $error("error status without tlast");

  // The status field only ever carries one of the defined codes.
  a_st_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ((m_axis_tuser_o == ST_OK) || (m_axis_tuser_o == ST_NO_DATA) ||
                         (m_axis_tuser_o == ST_PARTIAL)))
    else $error("unused status code");

  // When the queue is full the parser cannot have accepted a byte.
  a_full_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !in_fire)
    else $error("byte accepted while queue full");

endmodule

// ===== tb/wav_pcm16_stream_extractor_tb.sv =====
// Self-checking testbench for the WAV PCM16 stream extractor.
`timescale 1ns / 1ps

module wav_pcm16_stream_extractor_tb;
  import wpse_pkg::*;

  localparam int unsigned IdleLimit   = 4000;
  localparam int unsigned RandomBytes = 320;

  typedef struct packed {
    logic [16:0] mix;
    status_e     st;
    logic        last;
  } mix_result_t;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_COIN,
    RX_EVERY4,
    RX_LONG
  } rx_mode_e;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = '0;
  logic        s_axis_tlast_i  = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  wav_pcm16_stream_extractor uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Mirror of the chunk walker and frame assembler.
  logic [5:0]  byte_pos;
  phase_e      walk_phase;
  logic [1:0]  field_idx;
  logic [31:0] tag_shift;
  logic [31:0] size_accum;
  logic [31:0] skip_left;
  logic [7:0]  chan_count;
  logic [7:0]  low_byte;
  logic [15:0] left_word;
  logic [1:0]  frame_pos;

  mix_result_t expected_mixes[$];
  mix_result_t oldest_mix;
  logic [7:0]  wav_bytes[$];

  int unsigned err_count    = 0;
  int unsigned bytes_sent   = 0;
  int unsigned files_sent   = 0;
  int unsigned burst_left   = 0;
  int unsigned idle_cycles  = 0;
  int unsigned mixes_ok     = 0;
  int unsigned early_ends   = 0;
  int unsigned partial_ends = 0;

  function automatic void clear_parser();
    byte_pos   = '0;
    walk_phase = PH_RIFF;
    field_idx  = '0;
    tag_shift  = '0;
    size_accum = '0;
    skip_left  = '0;
    chan_count = '0;
    low_byte   = '0;
    left_word  = '0;
    frame_pos  = '0;
  endfunction

  // Advances the mirror by one file byte and queues the result it causes.
  function automatic void predict_mix(input logic [7:0] b, input logic eof);
    logic        emit;
    logic        in_data;
    logic [16:0] mix;
    logic [5:0]  pos;
    mix_result_t res;
    emit    = 1'b0;
    in_data = 1'b0;
    mix     = '0;
    pos     = byte_pos;
    // The channel byte is taken whatever the walker is doing at that offset.
    if (pos == ChanOffset) chan_count = b;
    if (byte_pos < OffsetSat) byte_pos = byte_pos + 6'd1;
    case (walk_phase)
      PH_ID: begin
        tag_shift = {tag_shift[23:0], b};
        if (field_idx == 2'd3) begin
          field_idx  = '0;
          size_accum = '0;
          if (tag_shift == DataId) walk_phase = PH_DSIZE;
          else walk_phase = PH_SIZE;
        end else begin
          field_idx = field_idx + 2'd1;
        end
      end
      PH_SIZE: begin
        size_accum = size_accum | ({24'd0, b} << {field_idx, 3'b000});
        if (field_idx == 2'd3) begin
          field_idx = '0;
          skip_left = size_accum;
          tag_shift = '0;
          if (size_accum == '0) walk_phase = PH_ID;
          else walk_phase = PH_SKIP;
        end else begin
          field_idx = field_idx + 2'd1;
        end
      end
      PH_SKIP: begin
        skip_left = skip_left - 32'd1;
        if (skip_left == '0) walk_phase = PH_ID;
      end
      PH_DSIZE: begin
        if (field_idx == 2'd3) begin
          field_idx  = '0;
          frame_pos  = '0;
          walk_phase = PH_SAMPLE;
        end else begin
          field_idx = field_idx + 2'd1;
        end
      end
      PH_SAMPLE: begin
        in_data = 1'b1;
        if (!frame_pos[0]) begin
          low_byte  = b;
          frame_pos = frame_pos + 2'd1;
        end else if (frame_pos == 2'd1) begin
          left_word = {b, low_byte};
          if (chan_count == StereoCnt) begin
            frame_pos = 2'd2;
          end else begin
            mix       = {left_word, 1'b0};
            emit      = 1'b1;
            frame_pos = '0;
          end
        end else begin
          // A frame that started as stereo finishes as stereo.
          mix       = {left_word[15], left_word} + {b[7], b, low_byte};
          emit      = 1'b1;
          frame_pos = '0;
        end
      end
      default: begin
        if (pos >= RiffLen) begin
          walk_phase = PH_ID;
          field_idx  = '0;
          tag_shift  = '0;
        end
      end
    endcase

    res.mix  = '0;
    res.last = eof;
    if (emit) begin
      res.mix = mix;
      res.st  = ST_OK;
    end else if (in_data) begin
      res.st = ST_PARTIAL;
    end else begin
      res.st = ST_NO_DATA;
    end
    if (emit || eof) expected_mixes.push_back(res);
    if (eof) clear_parser();
  endfunction

  // File image builders.
  function automatic void put_le(input logic [31:0] v, input int unsigned n);
    for (int i = 0; i < n; i++) wav_bytes.push_back(v[8*i +: 8]);
  endfunction

  function automatic void put_tag(input logic [31:0] tag);
    for (int i = 3; i >= 0; i--) wav_bytes.push_back(tag[8*i +: 8]);
  endfunction

  function automatic void put_noise(input int unsigned n);
    repeat (n) wav_bytes.push_back(8'($urandom));
  endfunction

  function automatic void start_wav(input logic [7:0] chans);
    wav_bytes.delete();
    put_tag("RIFF");
    put_le($urandom, 4);
    put_tag("WAVE");
    put_tag("fmt ");
    put_le(32'd16, 4);
    put_le(32'd1, 2);
    put_le({16'd0, 8'($urandom), chans}, 2);
    put_le(32'd44100, 4);
    put_le(32'd176400, 4);
    put_le(32'd4, 2);
    put_le(32'd16, 2);
  endfunction

  // RIFF header followed at once by the data chunk, so the channel byte
  // lands inside the sample data.
  function automatic void start_bare();
    wav_bytes.delete();
    put_tag("RIFF");
    put_le($urandom, 4);
    put_tag("WAVE");
    put_tag("data");
    put_le($urandom, 4);
  endfunction

  function automatic void build_random_wav();
    int unsigned pick;
    int unsigned extra;
    logic [31:0] len;
    pick = $urandom_range(0, 9);
    start_wav((pick < 6) ? 8'd2 : ((pick < 9) ? 8'd1 : 8'($urandom)));
    extra = $urandom_range(0, 2);
    repeat (extra) begin
      if ($urandom_range(0, 1) == 0) put_tag({24'h646174, 8'($urandom)});
      else put_tag($urandom);
      len = $urandom_range(0, 9);
      put_le(len, 4);
      put_noise(len);
    end
    put_tag("data");
    put_le($urandom, 4);
    put_noise($urandom_range(0, 64));
  endfunction

  // Sends one byte; entered and left just after a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned pause;
    if (burst_left == 0) begin
      if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(100, 300);
      else burst_left = $urandom_range(1, 24);
      pause = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (pause != 0) begin
        s_axis_tvalid_i = 1'b0;
        repeat (pause) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = b;
    s_axis_tlast_i  = last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_mix(b, last);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_file();
    foreach (wav_bytes[i]) send_byte(wav_bytes[i], i == wav_bytes.size() - 1);
    s_axis_tvalid_i = 1'b0;
    files_sent++;
  endtask

  task automatic wait_for_results();
    s_axis_tvalid_i = 1'b0;
    while (expected_mixes.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_early_end();
    wav_bytes.delete();
    put_noise(1);
    send_file();
    // Ends in the format chunk, before the channel byte.
    start_wav(8'd2);
    while (wav_bytes.size() > 21) void'(wav_bytes.pop_back());
    send_file();
    // Ends on the last byte of the data size field.
    start_wav(8'd1);
    put_tag("data");
    put_le(32'd0, 4);
    send_file();
  endtask

  task automatic test_mono_extremes();
    start_wav(8'd1);
    put_tag("data");
    put_le(32'd10, 4);
    put_le(32'h8000, 2);
    put_le(32'h7FFF, 2);
    put_le(32'h0000, 2);
    put_le(32'hFFFF, 2);
    put_le(32'h0001, 2);
    send_file();
    // A channel count other than two is treated as mono; odd tail dropped.
    start_wav(8'd0);
    put_tag("data");
    put_le(32'd3, 4);
    put_le(32'h8000, 2);
    put_noise(1);
    send_file();
  endtask

  task automatic test_stereo_extremes();
    start_wav(8'd2);
    put_tag("data");
    put_le(32'd18, 4);
    put_le(32'h8000_8000, 4);
    put_le(32'h7FFF_7FFF, 4);
    put_le(32'h7FFF_8000, 4);
    put_le(32'h0001_FFFF, 4);
    put_le(32'h1234, 2);
    send_file();
    start_wav(8'd2);
    put_tag("data");
    put_le(32'd7, 4);
    put_le(32'h8000_7FFF, 4);
    put_noise(3);
    send_file();
  endtask

  task automatic test_chunk_walk();
    start_wav(8'd2);
    put_tag("LIST");
    put_le(32'd3, 4);
    put_noise(3);
    put_tag("junk");
    put_le(32'd0, 4);
    put_tag("datb");
    put_le(32'd1, 4);
    put_noise(1);
    put_tag("DATA");
    put_le(32'd2, 4);
    put_noise(2);
    put_tag("pad ");
    put_le(32'd257, 4);
    put_noise(257);
    put_tag("data");
    put_le(32'hFFFF_FFFF, 4);
    put_noise(9);
    send_file();
  endtask

  task automatic test_huge_chunk();
    start_wav(8'd1);
    put_tag("big ");
    put_le(32'hFFFF_FFFF, 4);
    put_noise(40);
    send_file();
    // A data chunk inside a skipped region must stay skipped.
    start_wav(8'd2);
    put_tag("wide");
    put_le(32'h8000_0000, 4);
    put_tag("data");
    put_le(32'd8, 4);
    put_noise(8);
    send_file();
  endtask

  task automatic test_channel_in_samples();
    // First frame is mono, then the channel byte switches to stereo.
    start_bare();
    put_le(32'h8001, 2);
    put_le(32'h8002, 2);
    put_le(32'h7FFF, 2);
    send_file();
    start_bare();
    put_le(32'h7FFE, 2);
    put_le(32'hC001, 2);
    put_noise(1);
    send_file();
  endtask

  task automatic test_random_files();
    int unsigned first_byte;
    int unsigned pick;
    int unsigned cut;
    first_byte = bytes_sent;
    while (bytes_sent - first_byte < RandomBytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        build_random_wav();
      end else if (pick < 82) begin
        start_bare();
        put_noise($urandom_range(0, 24));
      end else if (pick < 92) begin
        build_random_wav();
        cut = $urandom_range(1, wav_bytes.size());
        while (wav_bytes.size() > cut) void'(wav_bytes.pop_back());
      end else begin
        wav_bytes.delete();
        put_noise($urandom_range(1, 48));
      end
      send_file();
      if ($urandom_range(0, 5) == 0) wait_for_results();
    end
  endtask

  // Output side stalls in modes of its own, picked at random.
  rx_mode_e    rx_mode   = RX_FREE;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;

  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      rx_mode   = rx_mode_e'($urandom_range(0, 3));
      mode_left = $urandom_range(40, 200);
    end
    mode_left--;
    case (rx_mode)
      RX_FREE:   m_axis_tready_i = 1'b1;
      RX_COIN:   m_axis_tready_i = 1'($urandom_range(0, 1));
      RX_EVERY4: m_axis_tready_i = (mode_left % 4 == 0);
      default: begin
        if (hold_left == 0) begin
          m_axis_tready_i = !m_axis_tready_i;
          hold_left = m_axis_tready_i ? $urandom_range(1, 4) : $urandom_range(1, 16);
        end
        hold_left--;
      end
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_mixes.size() == 0) begin
        err_count++;
        $display("%0t: result with none expected, got sample %0d status %0d last %0b",
                 $time, $signed(m_axis_tdata_o[16:0]), m_axis_tuser_o, m_axis_tlast_o);
      end else begin
        oldest_mix = expected_mixes.pop_front();
        case (oldest_mix.st)
          ST_OK:      mixes_ok++;
          ST_NO_DATA: early_ends++;
          default:    partial_ends++;
        endcase
        if (m_axis_tdata_o[16:0] !== oldest_mix.mix) begin
          err_count++;
          $display("%0t: mixed_sample mismatch, expected %0d, got %0d", $time,
                   $signed(oldest_mix.mix), $signed(m_axis_tdata_o[16:0]));
        end
        if (m_axis_tuser_o !== oldest_mix.st) begin
          err_count++;
          $display("%0t: status mismatch, expected %0d, got %0d", $time,
                   oldest_mix.st, m_axis_tuser_o);
        end
        if (m_axis_tlast_o !== oldest_mix.last) begin
          err_count++;
          $display("%0t: is_last mismatch, expected %0b, got %0b", $time,
                   oldest_mix.last, m_axis_tlast_o);
        end
      end
    end
  end

  // Watchdog: a long stretch without any transfer means the block hung.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
               idle_cycles, expected_mixes.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    clear_parser();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_early_end();
    wait_for_results();
    test_mono_extremes();
    wait_for_results();
    test_stereo_extremes();
    wait_for_results();
    test_chunk_walk();
    wait_for_results();
    test_huge_chunk();
    wait_for_results();
    test_channel_in_samples();
    wait_for_results();
    test_random_files();

    wait_for_results();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d files in %0d bytes, with random stalls on both streams.",
             files_sent, bytes_sent);
    $display("Checked %0d samples, %0d ends before data, %0d partial frames dropped.",
             mixes_ok, early_ends, partial_ends);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
